@@ design/lls_pkg.sv @@
// lls_pkg: shared types, constants and stencil tap tables for the lattice laplacian stencil
// no dependencies
package lls_pkg;

  localparam int DATA_W         = 32;
  localparam int DIM_W          = 7;
  localparam int POS_W          = 8;
  localparam int LEN_W          = 16;
  localparam int PROD_W         = 64;
  localparam int ACC_W          = 68;
  localparam int MAX_INTERIOR_X = 64;
  localparam int NUM_TAPS       = 13;
  localparam int NUM_ROWS       = 10;
  localparam int NUM_COLS       = 4;
  localparam int NUM_GROUPS     = 4;
  localparam int ROW_W          = 4;

  typedef enum logic [1:0] {
    MODE_ORTH = 2'd0,
    MODE_BCC  = 2'd1,
    MODE_FCC  = 2'd2,
    MODE_HEX  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_DIM_X  = 3'd1,
    REG_DIM_Y  = 3'd2,
    REG_DIM_Z  = 3'd3,
    REG_W_CTR  = 3'd4,
    REG_W_X    = 3'd5,
    REG_W_Y    = 3'd6,
    REG_W_Z    = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    W_C = 2'd0,
    W_X = 2'd1,
    W_Y = 2'd2,
    W_Z = 2'd3
  } wsel_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [1:0]       col;
    wsel_t            wsel;
    logic             used;
  } tap_t;

  // row 0 holds the newest samples, rows 1..9 come from the delay cells
  // rows: (0,1) (1,-1) (1,0) (1,1) (1,2) (2,-1) (2,0) (2,1) (2,2) in plane/line offsets
  localparam int ROW_SRC [NUM_ROWS] = '{0, 0, 1, 2, 3, 4, 4, 6, 7, 8};
  localparam bit ROW_PLANE [NUM_ROWS] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0,
                                          1'b0, 1'b0};

  localparam tap_t TAP_NONE = '{4'd0, 2'd0, W_C, 1'b0};

  localparam tap_t TAP_TBL [4][NUM_TAPS] = '{
    '{'{4'd3, 2'd1, W_C, 1'b1}, '{4'd7, 2'd1, W_X, 1'b1}, '{4'd0, 2'd1, W_X, 1'b1},
      '{4'd4, 2'd1, W_Y, 1'b1}, '{4'd2, 2'd1, W_Y, 1'b1}, '{4'd3, 2'd2, W_Z, 1'b1},
      '{4'd3, 2'd0, W_Z, 1'b1}, TAP_NONE, TAP_NONE, TAP_NONE, TAP_NONE, TAP_NONE,
      TAP_NONE},
    '{'{4'd4, 2'd2, W_C, 1'b1}, '{4'd9, 2'd3, W_X, 1'b1}, '{4'd8, 2'd2, W_X, 1'b1},
      '{4'd5, 2'd2, W_X, 1'b1}, '{4'd4, 2'd3, W_X, 1'b1}, '{4'd4, 2'd1, W_X, 1'b1},
      '{4'd3, 2'd2, W_X, 1'b1}, '{4'd1, 2'd2, W_X, 1'b1}, '{4'd0, 2'd1, W_X, 1'b1},
      TAP_NONE, TAP_NONE, TAP_NONE, TAP_NONE},
    '{'{4'd3, 2'd1, W_C, 1'b1}, '{4'd7, 2'd1, W_X, 1'b1}, '{4'd7, 2'd0, W_X, 1'b1},
      '{4'd6, 2'd1, W_X, 1'b1}, '{4'd4, 2'd1, W_X, 1'b1}, '{4'd4, 2'd0, W_X, 1'b1},
      '{4'd3, 2'd2, W_X, 1'b1}, '{4'd3, 2'd0, W_X, 1'b1}, '{4'd2, 2'd2, W_X, 1'b1},
      '{4'd2, 2'd1, W_X, 1'b1}, '{4'd1, 2'd1, W_X, 1'b1}, '{4'd0, 2'd2, W_X, 1'b1},
      '{4'd0, 2'd1, W_X, 1'b1}},
    '{'{4'd3, 2'd1, W_C, 1'b1}, '{4'd0, 2'd1, W_X, 1'b1}, '{4'd1, 2'd1, W_X, 1'b1},
      '{4'd4, 2'd1, W_X, 1'b1}, '{4'd7, 2'd1, W_X, 1'b1}, '{4'd6, 2'd1, W_X, 1'b1},
      '{4'd2, 2'd1, W_X, 1'b1}, '{4'd3, 2'd0, W_Z, 1'b1}, '{4'd3, 2'd2, W_Z, 1'b1},
      TAP_NONE, TAP_NONE, TAP_NONE, TAP_NONE}
  };

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v, input int maxv);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (int'(v) > maxv) r = DIM_W'(maxv);
    return r;
  endfunction

endpackage

@@ design/lls_if.sv @@
// lls_if: valid/ready stream interfaces for grid samples and stencil results
// depends on lls_pkg
interface lls_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [lls_pkg::DATA_W-1:0]   sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface lls_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [lls_pkg::DATA_W-1:0]   laplacian;
  logic                                overflow;
  logic                                last_point;
  modport source (output valid, output laplacian, output overflow, output last_point,
                  input ready);
  modport sink   (input valid, input laplacian, input overflow, input last_point,
                  output ready);
endinterface

@@ design/lls_cell.sv @@
// lls_cell: one delay cell of the tap chain, a circular line memory of runtime length
// plus a four-sample window; depends on lls_pkg
module lls_cell #(
  parameter int DEPTH = 66
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                restart,
  input  logic                                adv,
  input  logic [$clog2(DEPTH+1)-1:0]          len,
  input  logic [lls_pkg::DATA_W-1:0]          din,
  output logic [lls_pkg::DATA_W-1:0]          taps [lls_pkg::NUM_COLS]
);
  import lls_pkg::*;

  localparam int AW = $clog2(DEPTH + 1);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PW-1:0]     ptr_r, ptr_nxt;
  logic [DATA_W-1:0] win_r [NUM_COLS];

  always_comb begin
    ptr_nxt = ptr_r + PW'(1);
    if (AW'(ptr_r) == len - AW'(1)) ptr_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      ptr_r <= '0;
    end else if (adv) begin
      ptr_r <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mem[ptr_r] <= din;
      win_r[0]   <= mem[ptr_r];
      for (int i = 1; i < NUM_COLS; i++) win_r[i] <= win_r[i-1];
    end
  end

  assign taps = win_r;

endmodule

@@ design/lls_mac.sv @@
// lls_mac: weight multiply, sum tree, rounding and saturation pipeline
// depends on lls_pkg and lls_if
module lls_mac #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_last,
  input  logic signed [lls_pkg::DATA_W-1:0]   op_val [lls_pkg::NUM_TAPS],
  input  logic signed [lls_pkg::DATA_W-1:0]   op_wt  [lls_pkg::NUM_TAPS],
  output logic                                in_ready,
  lls_out_if.source                           out_bus
);
  import lls_pkg::*;

  localparam logic signed [ACC_W-1:0] RND = (ACC_W'(1) << FRAC_BITS) >> 1;

  logic                      v1_r, v2_r, v3_r, v4_r, v5_r;
  logic                      l1_r, l2_r, l3_r, l4_r, l5_r;
  logic                      rdy1, rdy2, rdy3, rdy4, rdy5;
  logic signed [DATA_W-1:0]  a_r [NUM_TAPS];
  logic signed [DATA_W-1:0]  b_r [NUM_TAPS];
  logic signed [PROD_W-1:0]  p_r [NUM_TAPS];
  logic signed [ACC_W-1:0]   ps_r [NUM_GROUPS];
  logic signed [ACC_W-1:0]   ps_nxt [NUM_GROUPS];
  logic signed [ACC_W-1:0]   sum_r, sum_nxt;
  logic signed [ACC_W-1:0]   q;
  logic                      fits;
  logic signed [DATA_W-1:0]  res_r, res_nxt;
  logic                      ovf_r, ovf_nxt;

  assign rdy5     = !v5_r || out_bus.ready;
  assign rdy4     = !v4_r || rdy5;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      ps_nxt[g] = '0;
      for (int k = 4 * g; k < 4 * g + 4; k++) begin
        if (k < NUM_TAPS) ps_nxt[g] = ps_nxt[g] + ACC_W'(p_r[k]);
      end
    end
    sum_nxt = RND;
    for (int g = 0; g < NUM_GROUPS; g++) sum_nxt = sum_nxt + ps_r[g];
  end

  always_comb begin
    q       = sum_r >>> FRAC_BITS;
    fits    = (&q[ACC_W-1:DATA_W-1]) || !(|q[ACC_W-1:DATA_W-1]);
    ovf_nxt = !fits;
    if (fits) res_nxt = q[DATA_W-1:0];
    else if (q[ACC_W-1]) res_nxt = {1'b1, {(DATA_W-1){1'b0}}};
    else res_nxt = {1'b0, {(DATA_W-1){1'b1}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      a_r  <= op_val;
      b_r  <= op_wt;
      l1_r <= in_last;
    end
    if (rdy2) begin
      for (int k = 0; k < NUM_TAPS; k++) p_r[k] <= a_r[k] * b_r[k];
      l2_r <= l1_r;
    end
    if (rdy3) begin
      ps_r <= ps_nxt;
      l3_r <= l2_r;
    end
    if (rdy4) begin
      sum_r <= sum_nxt;
      l4_r  <= l3_r;
    end
    if (rdy5) begin
      res_r <= res_nxt;
      ovf_r <= ovf_nxt;
      l5_r  <= l4_r;
    end
  end

  assign out_bus.valid      = v5_r;
  assign out_bus.laplacian  = res_r;
  assign out_bus.overflow   = ovf_r;
  assign out_bus.last_point = l5_r;

`ifndef SYNTHESIS
  a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r && ovf_r |-> (res_r == {1'b1, {(DATA_W-1){1'b0}}}) ||
                      (res_r == {1'b0, {(DATA_W-1){1'b1}}}))
    else $error("overflow without saturated value");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r && !out_bus.ready |=> v5_r && $stable(res_r))
    else $error("stalled result changed");
  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && rdy5 |=> v5_r)
    else $error("pipeline dropped a result");
`endif

endmodule

@@ design/lattice_laplacian_stencil_top.sv @@
// lattice_laplacian_stencil_top: streaming 3d laplacian over a padded grid, chain of delay cells
// depends on lls_pkg, lls_if, lls_cell and lls_mac
//
//   channel  dir  handshake        payload
//   in_bus   in   valid / ready    sample
//   out_bus  out  valid / ready    laplacian, overflow, last_point
//   cfg_*    in   cfg_we           cfg_index, cfg_wdata
//
// one sample per cycle unless the output stalls; results are registered through lls_mac
// the delay cells and tap window advance only on an accepted sample
// a stalled output holds the result pipeline; bubbles from non-emitting samples are absorbed
// reset or a write to the mode or a dimension register restarts the grid at its first corner
module lattice_laplacian_stencil_top #(
  parameter int MAX_DIM_Y = 64,
  parameter int MAX_DIM_Z = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  lls_in_if.sink                       in_bus,
  lls_out_if.source                    out_bus,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_index,
  input  logic [lls_pkg::DATA_W-1:0]   cfg_wdata
);
  import lls_pkg::*;

  localparam int LINE_DEPTH  = MAX_DIM_Z + 1;
  localparam int PLANE_DEPTH = MAX_DIM_Y * (MAX_DIM_Z + 2);
  localparam int LINE_AW     = $clog2(LINE_DEPTH + 1);
  localparam int PLANE_AW    = $clog2(PLANE_DEPTH + 1);

  mode_t                     mode_r;
  logic [DIM_W-1:0]          dim_x_r, dim_y_r, dim_z_r;
  logic signed [DATA_W-1:0]  weight_r [4];
  logic [POS_W-1:0]          pos_x_r, pos_y_r, pos_z_r;
  logic [POS_W-1:0]          lim_x, lim_y, lim_z;
  logic                      restart, accept, emit, last_pt, mac_ready;
  logic [POS_W-1:0]          incy;
  logic [LEN_W-1:0]          len_first, len_line, len_plane;
  logic [DATA_W-1:0]         taps [NUM_ROWS][NUM_COLS];
  logic [DATA_W-1:0]         head1_r, head2_r;
  logic signed [DATA_W-1:0]  op_val [NUM_TAPS];
  logic signed [DATA_W-1:0]  op_wt  [NUM_TAPS];
  tap_t                      tsel;

  assign restart = cfg_we && (reg_idx_t'(cfg_index) == REG_MODE ||
                              reg_idx_t'(cfg_index) == REG_DIM_X ||
                              reg_idx_t'(cfg_index) == REG_DIM_Y ||
                              reg_idx_t'(cfg_index) == REG_DIM_Z);
  assign in_bus.ready = mac_ready;
  assign accept       = in_bus.valid && mac_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_ORTH;
      dim_x_r <= DIM_W'(1);
      dim_y_r <= DIM_W'(1);
      dim_z_r <= DIM_W'(1);
      for (int i = 0; i < 4; i++) weight_r[i] <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_MODE:  mode_r      <= mode_t'(cfg_wdata[1:0]);
        REG_DIM_X: dim_x_r     <= clamp_dim(cfg_wdata[DIM_W-1:0], MAX_INTERIOR_X);
        REG_DIM_Y: dim_y_r     <= clamp_dim(cfg_wdata[DIM_W-1:0], MAX_DIM_Y);
        REG_DIM_Z: dim_z_r     <= clamp_dim(cfg_wdata[DIM_W-1:0], MAX_DIM_Z);
        REG_W_CTR: weight_r[0] <= cfg_wdata;
        REG_W_X:   weight_r[1] <= cfg_wdata;
        REG_W_Y:   weight_r[2] <= cfg_wdata;
        REG_W_Z:   weight_r[3] <= cfg_wdata;
        default:   ;
      endcase
    end
  end

  assign lim_x = POS_W'(dim_x_r) + POS_W'(1);
  assign lim_y = POS_W'(dim_y_r) + POS_W'(1);
  assign lim_z = POS_W'(dim_z_r) + POS_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
      pos_z_r <= '0;
    end else if (accept) begin
      if (pos_z_r == lim_z) begin
        pos_z_r <= '0;
        if (pos_y_r == lim_y) begin
          pos_y_r <= '0;
          pos_x_r <= (pos_x_r == lim_x) ? '0 : pos_x_r + POS_W'(1);
        end else begin
          pos_y_r <= pos_y_r + POS_W'(1);
        end
      end else begin
        pos_z_r <= pos_z_r + POS_W'(1);
      end
    end
  end

  always_comb begin
    if (mode_r == MODE_BCC) begin
      emit    = pos_x_r >= POS_W'(2) && pos_y_r >= POS_W'(2) && pos_z_r >= POS_W'(2);
      last_pt = pos_x_r == lim_x && pos_y_r == lim_y && pos_z_r == lim_z;
    end else begin
      emit    = pos_x_r >= POS_W'(2) && pos_y_r >= POS_W'(1) && pos_y_r <= POS_W'(dim_y_r) &&
                pos_z_r >= POS_W'(1) && pos_z_r <= POS_W'(dim_z_r);
      last_pt = pos_x_r == lim_x && pos_y_r == POS_W'(dim_y_r) && pos_z_r == POS_W'(dim_z_r);
    end
  end

  // runtime lengths of the delay cells
  assign incy      = POS_W'(dim_z_r) + POS_W'(2);
  assign len_first = LEN_W'(dim_z_r);
  assign len_line  = LEN_W'(dim_z_r) + LEN_W'(1);
  assign len_plane = LEN_W'(dim_y_r) * LEN_W'(incy) - LEN_W'(1);

  always_ff @(posedge clk) begin
    if (accept) begin
      head1_r <= in_bus.sample;
      head2_r <= head1_r;
    end
  end

  assign taps[0][0] = in_bus.sample;
  assign taps[0][1] = in_bus.sample;
  assign taps[0][2] = head1_r;
  assign taps[0][3] = head2_r;

  for (genvar gr = 1; gr < NUM_ROWS; gr++) begin : g_row
    if (ROW_PLANE[gr]) begin : g_plane
      lls_cell #(.DEPTH(PLANE_DEPTH)) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (restart),
        .adv     (accept),
        .len     (PLANE_AW'(len_plane)),
        .din     (taps[ROW_SRC[gr]][0]),
        .taps    (taps[gr])
      );
    end else begin : g_line
      lls_cell #(.DEPTH(LINE_DEPTH)) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (restart),
        .adv     (accept),
        .len     ((gr == 1) ? LINE_AW'(len_first) : LINE_AW'(len_line)),
        .din     (taps[ROW_SRC[gr]][0]),
        .taps    (taps[gr])
      );
    end
  end

  always_comb begin
    tsel = TAP_NONE;
    for (int k = 0; k < NUM_TAPS; k++) begin
      tsel      = TAP_TBL[mode_r][k];
      op_val[k] = tsel.used ? taps[tsel.row][tsel.col] : '0;
      op_wt[k]  = tsel.used ? weight_r[tsel.wsel] : '0;
    end
  end

  lls_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (accept && emit),
    .in_last  (last_pt),
    .op_val   (op_val),
    .op_wt    (op_wt),
    .in_ready (mac_ready),
    .out_bus  (out_bus)
  );

`ifndef SYNTHESIS
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    restart |=> pos_x_r == '0 && pos_y_r == '0 && pos_z_r == '0)
    else $error("grid did not restart");
  a_pos_z: assert property (@(posedge clk) disable iff (!rst_n)
    pos_z_r <= lim_z && pos_y_r <= lim_y && pos_x_r <= lim_x)
    else $error("position counter out of range");
  a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !restart && pos_z_r == lim_z |=> pos_z_r == '0)
    else $error("z counter failed to wrap");
`endif

endmodule
